>>> rtl/radio_frame_receiver_xor_fcs_defines.svh
// ----------------------------------------------------------------------------
// Frame receiver assertion macros
// Shared concurrent assertion forms for the frame receiver checkers.
// ----------------------------------------------------------------------------
`ifndef RADIO_FRAME_RECEIVER_XOR_FCS_DEFINES_SVH
`define RADIO_FRAME_RECEIVER_XOR_FCS_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RFR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RFR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rfr_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Types and fixed constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned MinFrameBytes = 8;
  localparam int unsigned PayloadStart  = 6;

  localparam logic [7:0] StartByteRst   = 8'hFE;
  localparam logic [7:0] CmdFirstRst    = 8'h44;
  localparam logic [7:0] CmdSecondRst   = 8'h5F;
  localparam logic [7:0] LenOffset      = 8'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_BYTE = 2'd0,
    REG_CMD_FIRST  = 2'd1,
    REG_CMD_SECOND = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_RX_BYTE = 1'b0,
    CMD_EOF     = 1'b1
  } command_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CHECK    = 3'd2,
    ST_HEADER   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    command_e   command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [15:0] src_addr;
    logic [7:0]  payload_len;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] cmd_first;
    logic [7:0] cmd_second;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctl_t;

endpackage

>>> rtl/rfr_in_if.sv
// ----------------------------------------------------------------------------
// Frame receiver input channel
// Valid/ready channel carrying one received byte or an end-of-frame request.
// ----------------------------------------------------------------------------
interface rfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

>>> rtl/rfr_out_if.sv
// ----------------------------------------------------------------------------
// Frame receiver output channel
// Valid/ready channel carrying payload byte and frame status results.
// ----------------------------------------------------------------------------
interface rfr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [15:0] src_addr;
  logic [7:0]  payload_len;
  logic        last;

  modport source (output valid, output kind, output payload_byte, output status,
                  output src_addr, output payload_len, output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input status,
                input src_addr, input payload_len, input last, output ready);
endinterface

>>> rtl/rfr_in_stage.sv
// ----------------------------------------------------------------------------
// Frame receiver input stage
// Registers one input request and offers it to the frame logic.
// ----------------------------------------------------------------------------
module rfr_in_stage import rfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  in_item_t  item_i,
  input  logic      advance_i,
  output pipe_ctl_t ctl_o,
  output in_item_t  item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign ctl_o.valid   = valid_q;
  assign ctl_o.advance = advance_i;
  assign item_o        = item_q;

endmodule

>>> rtl/rfr_frame_ctrl.sv
// ----------------------------------------------------------------------------
// Frame receiver frame logic
// Holds the configuration and frame state and builds the result of a request.
// ----------------------------------------------------------------------------
module rfr_frame_ctrl import rfr_pkg::*; #(
  parameter int unsigned MaxFrameBytes = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  pipe_ctl_t          ctl_i,
  input  in_item_t           item_i,
  output logic               res_valid_o,
  output result_t            res_o
);

  localparam int unsigned IdxW = $clog2(MaxFrameBytes + 1);

  cfg_t        cfg_q, cfg_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  held_q, held_d;
  logic        hdr_good_q, hdr_good_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] addr_q, addr_d;
  logic        ovf_q, ovf_d;
  logic        proc;
  logic        full;
  status_e     status;

  assign proc = ctl_i.valid && ctl_i.advance;
  assign full = idx_q >= IdxW'(MaxFrameBytes);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_BYTE: cfg_d.start_byte = cfg_wdata_i;
        REG_CMD_FIRST:  cfg_d.cmd_first  = cfg_wdata_i;
        REG_CMD_SECOND: cfg_d.cmd_second = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    if (ovf_q) begin
      status = ST_OVERFLOW;
    end else if (idx_q < IdxW'(MinFrameBytes)) begin
      status = ST_SHORT;
    end else if (xor_q != 8'd0) begin
      status = ST_CHECK;
    end else if (!hdr_good_q) begin
      status = ST_HEADER;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    xor_d       = xor_q;
    held_d      = held_q;
    hdr_good_d  = hdr_good_q;
    len_d       = len_q;
    addr_d      = addr_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (proc) begin
      if (item_i.command == CMD_EOF) begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_STATUS;
        res_o.status      = status;
        res_o.src_addr    = addr_q;
        res_o.payload_len = len_q - LenOffset;
        res_o.last        = 1'b1;
        idx_d      = '0;
        xor_d      = '0;
        held_d     = '0;
        hdr_good_d = 1'b1;
        len_d      = '0;
        addr_d     = '0;
        ovf_d      = 1'b0;
      end else if (full) begin
        ovf_d = 1'b1;
      end else begin
        if (idx_q == '0) begin
          if (item_i.rx_byte != cfg_q.start_byte) begin
            hdr_good_d = 1'b0;
          end
        end else begin
          xor_d = xor_q ^ item_i.rx_byte;
        end
        if (idx_q == IdxW'(1)) begin
          len_d = item_i.rx_byte;
        end
        if ((idx_q == IdxW'(2)) && (item_i.rx_byte != cfg_q.cmd_first)) begin
          hdr_good_d = 1'b0;
        end
        if ((idx_q == IdxW'(3)) && (item_i.rx_byte != cfg_q.cmd_second)) begin
          hdr_good_d = 1'b0;
        end
        if (idx_q == IdxW'(4)) begin
          addr_d[7:0] = item_i.rx_byte;
        end
        if (idx_q == IdxW'(5)) begin
          addr_d[15:8] = item_i.rx_byte;
        end
        if (idx_q > IdxW'(PayloadStart)) begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_PAYLOAD;
          res_o.payload_byte = held_q;
        end
        if (idx_q >= IdxW'(PayloadStart)) begin
          held_d = item_i.rx_byte;
        end
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= StartByteRst;
      cfg_q.cmd_first  <= CmdFirstRst;
      cfg_q.cmd_second <= CmdSecondRst;
      idx_q            <= '0;
      xor_q            <= '0;
      held_q           <= '0;
      hdr_good_q       <= 1'b1;
      len_q            <= '0;
      addr_q           <= '0;
      ovf_q            <= 1'b0;
    end else begin
      cfg_q      <= cfg_d;
      idx_q      <= idx_d;
      xor_q      <= xor_d;
      held_q     <= held_d;
      hdr_good_q <= hdr_good_d;
      len_q      <= len_d;
      addr_q     <= addr_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

>>> rtl/rfr_out_stage.sv
// ----------------------------------------------------------------------------
// Frame receiver output stage
// Result register that holds a result until the receiver takes it.
// ----------------------------------------------------------------------------
module rfr_out_stage import rfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    advance_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign advance_o = !valid_q || ready_i;
  assign valid_d   = advance_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> rtl/radio_frame_receiver_xor_fcs.sv
// ----------------------------------------------------------------------------
// Radio frame receiver with XOR check
// Parses received frame bytes, forwards payload and reports frame status.
// ----------------------------------------------------------------------------
// Each request on in_i is either a received byte or an end-of-frame event.
// Payload bytes from index 6 onwards leave on out_o one byte late, so the
// trailing check byte is never forwarded. An end-of-frame request yields a
// single status result with last set, carrying the source address and the
// length field minus two, and clears the frame state.
// The block takes one request per cycle while out_o is not stalled. A
// request is registered on acceptance, and its result is registered in the
// result register once that register can advance. The two registers form
// a pipeline; when the receiver stalls, the result register holds and the
// input register keeps accepting until it is also full.
// Reset empties both registers, clears the frame state and loads the
// default start and command bytes. Configuration writes through cfg_we_i
// take effect on the next request.
// ----------------------------------------------------------------------------
module radio_frame_receiver_xor_fcs import rfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rfr_in_if.sink             in_i,
  rfr_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i
);

  in_item_t  in_item, stage_item;
  pipe_ctl_t stage_ctl;
  logic      advance;
  logic      res_valid;
  result_t   res, out_res;

  assign in_item.command = command_e'(in_i.command);
  assign in_item.rx_byte = in_i.rx_byte;

  rfr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .item_i    (in_item),
    .advance_i (advance),
    .ctl_o     (stage_ctl),
    .item_o    (stage_item)
  );

  rfr_frame_ctrl #(
    .MaxFrameBytes (MAX_FRAME_BYTES)
  ) u_frame_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (stage_ctl),
    .item_i      (stage_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .res_o       (out_res)
  );

  assign out_o.kind         = out_res.kind;
  assign out_o.payload_byte = out_res.payload_byte;
  assign out_o.status       = out_res.status;
  assign out_o.src_addr     = out_res.src_addr;
  assign out_o.payload_len  = out_res.payload_len;
  assign out_o.last         = out_res.last;

endmodule

>>> rtl/rfr_checker.sv
// ----------------------------------------------------------------------------
// Frame receiver checker
// Port-level assertions on the frame receiver, attached by bind.
// ----------------------------------------------------------------------------
`include "radio_frame_receiver_xor_fcs_defines.svh"

module rfr_checker import rfr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic [7:0]  out_payload_byte_i,
  input logic [2:0]  out_status_i,
  input logic [15:0] out_src_addr_i,
  input logic [7:0]  out_payload_len_i,
  input logic        out_last_i
);

  `RFR_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_status_i) && $stable(out_payload_byte_i),
    "stalled result changed")
  `RFR_ASSERT_IMP(a_payload_clean, out_valid_i && (out_kind_i == KIND_PAYLOAD),
    !out_last_i && (out_status_i == ST_OK) && (out_src_addr_i == 16'd0) &&
    (out_payload_len_i == 8'd0),
    "payload result carries status fields")
  `RFR_ASSERT_IMP(a_status_form, out_valid_i && (out_kind_i == KIND_STATUS),
    out_last_i && (out_payload_byte_i == 8'd0) && (out_status_i <= ST_OVERFLOW),
    "malformed status result")

endmodule

bind radio_frame_receiver_xor_fcs rfr_checker u_rfr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_kind_i         (out_o.kind),
  .out_payload_byte_i (out_o.payload_byte),
  .out_status_i       (out_o.status),
  .out_src_addr_i     (out_o.src_addr),
  .out_payload_len_i  (out_o.payload_len),
  .out_last_i         (out_o.last)
);

>>> tb/radio_frame_receiver_xor_fcs_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio frame receiver testbench
// Drives received bytes and end-of-frame requests into the frame receiver,
// predicts every payload byte and frame status in a parallel frame parser,
// and checks each result field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module radio_frame_receiver_xor_fcs_test;
  import rfr_pkg::*;

  localparam int unsigned MaxFrameBytes  = 128;
  localparam int unsigned CycleLimit     = 100000;
  localparam int unsigned StallCycles    = 60;
  localparam int unsigned DrainCycles    = 6;
  localparam int unsigned RandomPerPhase = 200;
  localparam int unsigned WholeFrame     = 1024;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef enum int {
    FLAW_NONE,
    FLAW_START,
    FLAW_CMD_FIRST,
    FLAW_CMD_SECOND,
    FLAW_CHECK,
    FLAW_SHORT
  } frame_flaw_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [7:0]         cfg_wdata = '0;

  rfr_in_if  in_ch ();
  rfr_out_if out_ch ();

  radio_frame_receiver_xor_fcs dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Register copies and frame state of the parallel parser.
  logic [7:0]  exp_start;
  logic [7:0]  exp_cmd_first;
  logic [7:0]  exp_cmd_second;
  logic [7:0]  fr_index;
  logic [7:0]  fr_xor;
  logic [7:0]  fr_held;
  logic [7:0]  fr_len;
  logic [15:0] fr_addr;
  logic        fr_hdr_ok;
  logic        fr_ovf;

  in_item_t    rx_requests[$];
  result_t     awaited_results[$];
  logic        in_taken = 1'b0;
  int unsigned send_gap_pct = 0;
  int unsigned take_gap_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_wanted = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned requests_taken = 0;
  int unsigned payload_count = 0;
  int unsigned status_tally[5];

  always #6 clk_i = ~clk_i;

  function automatic void clear_frame_state();
    fr_index  = '0;
    fr_xor    = '0;
    fr_held   = '0;
    fr_len    = '0;
    fr_addr   = '0;
    fr_hdr_ok = 1'b1;
    fr_ovf    = 1'b0;
  endfunction

  function automatic void parse_rx_request(in_item_t req);
    result_t res;
    res = '0;
    if (req.command == CMD_EOF) begin
      res.kind = KIND_STATUS;
      res.last = 1'b1;
      if (fr_ovf) res.status = ST_OVERFLOW;
      else if (fr_index < MinFrameBytes) res.status = ST_SHORT;
      else if (fr_xor != 8'h00) res.status = ST_CHECK;
      else if (!fr_hdr_ok) res.status = ST_HEADER;
      else res.status = ST_OK;
      res.src_addr    = fr_addr;
      res.payload_len = fr_len - LenOffset;
      awaited_results.push_back(res);
      clear_frame_state();
    end else if (fr_index >= MaxFrameBytes) begin
      fr_ovf = 1'b1;
    end else begin
      if (fr_index == 8'd0) begin
        if (req.rx_byte != exp_start) fr_hdr_ok = 1'b0;
      end else begin
        fr_xor = fr_xor ^ req.rx_byte;
      end
      case (fr_index)
        8'd1: fr_len = req.rx_byte;
        8'd2: if (req.rx_byte != exp_cmd_first) fr_hdr_ok = 1'b0;
        8'd3: if (req.rx_byte != exp_cmd_second) fr_hdr_ok = 1'b0;
        8'd4: fr_addr[7:0] = req.rx_byte;
        8'd5: fr_addr[15:8] = req.rx_byte;
        default: ;
      endcase
      if (fr_index > PayloadStart) begin
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = fr_held;
        awaited_results.push_back(res);
      end
      if (fr_index >= PayloadStart) fr_held = req.rx_byte;
      fr_index = fr_index + 8'd1;
    end
  endfunction

  function automatic void push_rx_byte(logic [7:0] b);
    in_item_t r;
    r.command = CMD_RX_BYTE;
    r.rx_byte = b;
    rx_requests.push_back(r);
  endfunction

  function automatic void push_eof();
    in_item_t r;
    r.command = CMD_EOF;
    r.rx_byte = 8'($urandom);
    rx_requests.push_back(r);
  endfunction

  function automatic int unsigned push_checked_frame(logic [7:0] fb[$], bit spoil_check,
                                                     int unsigned keep);
    logic [7:0]  chk;
    int unsigned i;
    chk = '0;
    for (i = 1; i < fb.size(); i++) chk = chk ^ fb[i];
    if (spoil_check) chk = chk ^ 8'($urandom_range(255, 1));
    fb.push_back(chk);
    if (keep > fb.size()) keep = fb.size();
    for (i = 0; i < keep; i++) push_rx_byte(fb[i]);
    push_eof();
    return keep + 1;
  endfunction

  function automatic int unsigned push_frame(int unsigned n_pay, frame_flaw_e flaw);
    logic [7:0]  fb[$];
    logic [15:0] addr;
    addr = 16'($urandom);
    fb.push_back(exp_start ^ ((flaw == FLAW_START) ? 8'($urandom_range(255, 1)) : 8'h00));
    fb.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'(n_pay + 2));
    fb.push_back(exp_cmd_first ^
                 ((flaw == FLAW_CMD_FIRST) ? 8'($urandom_range(255, 1)) : 8'h00));
    fb.push_back(exp_cmd_second ^
                 ((flaw == FLAW_CMD_SECOND) ? 8'($urandom_range(255, 1)) : 8'h00));
    fb.push_back(addr[7:0]);
    fb.push_back(addr[15:8]);
    repeat (n_pay) fb.push_back(8'($urandom));
    return push_checked_frame(fb, flaw == FLAW_CHECK,
                              (flaw == FLAW_SHORT) ? $urandom_range(7) : WholeFrame);
  endfunction

  // Mostly well-formed frames; the rest carry one flaw each or are loose noise.
  function automatic void add_random_frames(int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    frame_flaw_e flaw;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 60) flaw = FLAW_NONE;
      else if (pick < 66) flaw = FLAW_START;
      else if (pick < 72) flaw = FLAW_CMD_FIRST;
      else if (pick < 78) flaw = FLAW_CMD_SECOND;
      else if (pick < 88) flaw = FLAW_CHECK;
      else flaw = FLAW_SHORT;
      if (pick >= 94) begin
        n = $urandom_range(12);
        repeat (n) push_rx_byte(8'($urandom));
        push_eof();
        sent += n + 1;
      end else begin
        n = ($urandom_range(49) == 0) ? $urandom_range(126, 121) : $urandom_range(12);
        sent += push_frame(n, flaw);
      end
    end
  endfunction

  task automatic wait_until_idle();
    do @(negedge clk_i);
    while (rx_requests.size() != 0 || requests_sent != requests_taken ||
           awaited_results.size() != 0);
  endtask

  task automatic write_settings(logic [7:0] start_v, logic [7:0] cmd1_v,
                                logic [7:0] cmd2_v);
    logic [CfgIdxW-1:0] order [4] = '{REG_START_BYTE, REG_CMD_FIRST, REG_CMD_SECOND,
                                      RegUnused};
    int unsigned k;
    wait_until_idle();
    repeat (DrainCycles) @(negedge clk_i);
    for (k = 0; k < 4; k++) begin
      cfg_idx <= order[k];
      case (order[k])
        REG_START_BYTE: begin
          cfg_wdata <= start_v;
          exp_start = start_v;
        end
        REG_CMD_FIRST: begin
          cfg_wdata <= cmd1_v;
          exp_cmd_first = cmd1_v;
        end
        REG_CMD_SECOND: begin
          cfg_wdata <= cmd2_v;
          exp_cmd_second = cmd2_v;
        end
        default: cfg_wdata <= 8'($urandom);
      endcase
      cfg_we <= 1'b1;
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk_i) begin
    in_item_t next_req;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (rx_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_req = rx_requests.pop_front();
        requests_sent++;
        in_ch.valid   <= 1'b1;
        in_ch.command <= next_req.command;
        in_ch.rx_byte <= next_req.rx_byte;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= take_gap_pct);
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_wanted) hold_left <= StallCycles;
  end

  always @(posedge clk_i) begin
    in_item_t got_req;
    result_t  want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        got_req.command = command_e'(in_ch.command);
        got_req.rx_byte = in_ch.rx_byte;
        parse_rx_request(got_req);
        requests_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("Result with kind %0d arrived while none was expected", out_ch.kind);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
          check_field("status", want.status, out_ch.status);
          check_field("src_addr", want.src_addr, out_ch.src_addr);
          check_field("payload_len", want.payload_len, out_ch.payload_len);
          check_field("last", want.last, out_ch.last);
          if (want.kind == KIND_STATUS) status_tally[want.status]++;
          else payload_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("radio_frame_receiver_xor_fcs_test: errors");
      $finish;
    end
  end

  initial begin
    logic [7:0] dir_bytes[$];
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_RX_BYTE;
    in_ch.rx_byte  = '0;
    out_ch.ready   = 1'b0;
    exp_start      = StartByteRst;
    exp_cmd_first  = CmdFirstRst;
    exp_cmd_second = CmdSecondRst;
    clear_frame_state();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct = 9;
    take_gap_pct = 50;
    write_settings(StartByteRst, CmdFirstRst, CmdSecondRst);
    // An empty frame, a truncated header, a good frame with extreme payload
    // and address bytes, and a minimum-length frame with a bad check byte.
    push_eof();
    push_rx_byte(exp_start);
    push_rx_byte(8'hFF);
    push_rx_byte(8'h00);
    push_eof();
    dir_bytes = '{exp_start, 8'h04, exp_cmd_first, exp_cmd_second, 8'hFF, 8'h00,
                  8'h00, 8'hFF};
    void'(push_checked_frame(dir_bytes, 1'b0, WholeFrame));
    dir_bytes = '{exp_start, 8'h00, exp_cmd_first, exp_cmd_second, 8'hFF, 8'hFF, 8'h5A};
    void'(push_checked_frame(dir_bytes, 1'b1, WholeFrame));

    write_settings(8'h00, 8'h00, 8'h00);
    add_random_frames(RandomPerPhase / 2);
    wait_until_idle();
    add_random_frames(RandomPerPhase / 2);

    write_settings(8'hFF, 8'hFF, 8'hFF);
    send_gap_pct = 50;
    take_gap_pct = 9;
    add_random_frames(RandomPerPhase);

    write_settings(8'($urandom), 8'($urandom), 8'($urandom));
    send_gap_pct = 0;
    take_gap_pct = 0;
    // One byte beyond the frame buffer while the receiver holds off.
    void'(push_frame(MaxFrameBytes - 6, FLAW_NONE));
    add_random_frames(RandomPerPhase);
    hold_wanted = 1'b1;
    while (hold_left == 0) @(negedge clk_i);
    hold_wanted = 1'b0;

    wait_until_idle();
    repeat (DrainCycles) @(negedge clk_i);
    $display("Checked %0d requests, %0d payload bytes, four register settings.",
             requests_taken, payload_count);
    $display("Frames: ok %0d, short %0d, check %0d, header %0d, overflow %0d.",
             status_tally[ST_OK], status_tally[ST_SHORT], status_tally[ST_CHECK],
             status_tally[ST_HEADER], status_tally[ST_OVERFLOW]);
    if (mismatches == 0) begin
      $display("radio_frame_receiver_xor_fcs_test: clean");
    end else begin
      $display("radio_frame_receiver_xor_fcs_test: errors");
    end
    $finish;
  end

endmodule
